// ===== sv/sirs_pkg.sv =====
// Shared types and constants for the sorted index range search block.
// No dependencies; used by sirs_bisect and sorted_index_range_search_top.
`default_nettype none

package sirs_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;
   localparam int KEY_W       = 32;

   // request command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // control from the sequencer to the bisection datapath
   typedef struct packed {
      logic init;      // load lo = 0, hi = n
      logic step;      // apply one halving with go_right
      logic go_right;  // 1: lo = mid + 1, 0: hi = mid
   } bisect_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/sorted_index_range_search_top.sv =====
// Top level of the sorted index range search block: key memory and sequencer.
// Depends on sirs_pkg and sirs_bisect.
//
// Usage: a request is taken when start is high and busy is low. With
// req_cmd = write, req_entry_key is stored at req_entry_index in that same
// cycle; busy stays low and no response follows. With req_cmd = query, the
// block finds the first index whose key is at least req_low_bound and the
// last index whose key is at most req_high_bound among the first
// value_count keys, and returns them with the match count on the rsp_ ports,
// marked by a one-cycle rsp_valid. The receiver cannot stall responses.
// csr_value_count is written through csr_valid/csr_ready while idle; values
// above the table depth are clamped.
// Sequence: an empty table answers in the cycle after the request. Otherwise
// the states ST_CHK_LAST, ST_CHK_FIRST and ST_CHK_EVAL read and check the first
// and last keys; a missed range then answers. A hit runs two binary searches,
// each halving in a read state and a compare state, plus an exit through the
// read state per search; the response appears in the first cycle with busy low.
// The single memory read port and the single comparator set this read/compare split.
// Reset clears the sequencer and value_count; the key memory is not cleared.
`default_nettype none

module sorted_index_range_search_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_cmd,
   input  wire logic        [sirs_pkg::IDX_W-1:0]   req_entry_index,
   input  wire logic signed [sirs_pkg::KEY_W-1:0]   req_entry_key,
   input  wire logic signed [sirs_pkg::KEY_W-1:0]   req_low_bound,
   input  wire logic signed [sirs_pkg::KEY_W-1:0]   req_high_bound,
   // response channel
   output logic                                     rsp_valid,
   output logic             [sirs_pkg::CNT_W-1:0]   rsp_range_start,
   output logic signed      [sirs_pkg::CNT_W-1:0]   rsp_range_end,
   output logic             [sirs_pkg::CNT_W-1:0]   rsp_match_count,
   // configuration
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic        [sirs_pkg::CNT_W-1:0]   csr_value_count
);

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_CHK_LAST  = 8'b0000_0010,
      ST_CHK_FIRST = 8'b0000_0100,
      ST_CHK_EVAL  = 8'b0000_1000,
      ST_LOW_RD    = 8'b0001_0000,
      ST_LOW_CMP   = 8'b0010_0000,
      ST_UP_RD     = 8'b0100_0000,
      ST_UP_CMP    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic signed [sirs_pkg::KEY_W-1:0] key_mem [sirs_pkg::TABLE_DEPTH];
   logic signed [sirs_pkg::KEY_W-1:0] rd_data_ff;
   logic        [sirs_pkg::IDX_W-1:0] rd_addr;

   logic        [sirs_pkg::CNT_W-1:0] count_cfg_ff;
   logic signed [sirs_pkg::KEY_W-1:0] low_ff;
   logic signed [sirs_pkg::KEY_W-1:0] high_ff;
   logic                              miss_ff, miss_in;
   logic        [sirs_pkg::CNT_W-1:0] start_ff, start_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic        [sirs_pkg::CNT_W-1:0] rsp_start_ff, rsp_start_in;
   logic        [sirs_pkg::CNT_W-1:0] rsp_end_ff, rsp_end_in;
   logic        [sirs_pkg::CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic signed [sirs_pkg::KEY_W-1:0] cmp_a, cmp_b;
   logic                              cmp_lt;

   sirs_pkg::bisect_ctrl_type         bis_ctrl;
   logic        [sirs_pkg::IDX_W-1:0] bis_mid;
   logic        [sirs_pkg::CNT_W-1:0] bis_lo;
   logic                              bis_active;

   logic accept, wr_accept, query_accept;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign wr_accept    = accept && (req_cmd == sirs_pkg::CMD_WRITE);
   assign query_accept = accept && (req_cmd == sirs_pkg::CMD_QUERY);
   assign csr_ready    = !busy;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_start = rsp_start_ff;
   assign rsp_range_end   = $signed(rsp_end_ff);
   assign rsp_match_count = rsp_count_ff;

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_accept) begin
         key_mem[req_entry_index] <= req_entry_key;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   // read address per state
   always_comb begin
      case (state_ff)
         ST_CHK_LAST: rd_addr = sirs_pkg::IDX_W'(count_cfg_ff - sirs_pkg::CNT_W'(1));
         ST_LOW_RD:   rd_addr = bis_mid;
         ST_UP_RD:    rd_addr = bis_mid;
         default:     rd_addr = '0;
      endcase
   end

   // shared signed comparator: cmp_lt = cmp_a < cmp_b
   always_comb begin
      case (state_ff)
         ST_CHK_EVAL, ST_UP_CMP: begin
            cmp_a = high_ff;
            cmp_b = rd_data_ff;
         end
         default: begin
            cmp_a = rd_data_ff;
            cmp_b = low_ff;
         end
      endcase
   end
   assign cmp_lt = cmp_a < cmp_b;

   sirs_bisect u_bisect (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (bis_ctrl),
      .n      (count_cfg_ff),
      .mid    (bis_mid),
      .lo     (bis_lo),
      .active (bis_active)
   );

   // sequencer
   always_comb begin
      state_in         = state_ff;
      miss_in          = miss_ff;
      start_in         = start_ff;
      bis_ctrl         = '0;
      rsp_valid_in     = 1'b0;
      rsp_start_in     = rsp_start_ff;
      rsp_end_in       = rsp_end_ff;
      rsp_count_in     = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               if (count_cfg_ff == '0) begin
                  // empty table
                  rsp_valid_in = 1'b1;
                  rsp_start_in = '0;
                  rsp_end_in   = '1;
                  rsp_count_in = '0;
               end else begin
                  state_in = ST_CHK_LAST;
               end
            end
         end
         ST_CHK_LAST: begin
            state_in = ST_CHK_FIRST;
         end
         ST_CHK_FIRST: begin
            // last key below low bound
            miss_in  = cmp_lt;
            state_in = ST_CHK_EVAL;
         end
         ST_CHK_EVAL: begin
            // high bound below first key
            if (miss_ff || cmp_lt) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = '0;
               rsp_end_in   = '1;
               rsp_count_in = '0;
               state_in     = ST_IDLE;
            end else begin
               bis_ctrl.init = 1'b1;
               state_in      = ST_LOW_RD;
            end
         end
         ST_LOW_RD: begin
            if (bis_active) begin
               state_in = ST_LOW_CMP;
            end else begin
               start_in      = bis_lo;
               bis_ctrl.init = 1'b1;
               state_in      = ST_UP_RD;
            end
         end
         ST_LOW_CMP: begin
            bis_ctrl.step     = 1'b1;
            bis_ctrl.go_right = cmp_lt;
            state_in          = ST_LOW_RD;
         end
         ST_UP_RD: begin
            if (bis_active) begin
               state_in = ST_UP_CMP;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_start_in = start_ff;
               rsp_end_in   = bis_lo - sirs_pkg::CNT_W'(1);
               rsp_count_in = (bis_lo > start_ff) ? (bis_lo - start_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         ST_UP_CMP: begin
            bis_ctrl.step     = 1'b1;
            bis_ctrl.go_right = !cmp_lt;
            state_in          = ST_UP_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_cfg_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_cfg_ff <= (csr_value_count > sirs_pkg::CNT_W'(sirs_pkg::TABLE_DEPTH))
                            ? sirs_pkg::CNT_W'(sirs_pkg::TABLE_DEPTH) : csr_value_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (query_accept) begin
         low_ff  <= req_low_bound;
         high_ff <= req_high_bound;
      end
      miss_ff      <= miss_in;
      start_ff     <= start_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_count_ff <= rsp_count_in;
   end

`ifndef NO_ASSERTIONS
   // a response follows a query in progress or an empty-table query
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start || busy))
      else $error("response without a query");

   // a response is only presented while the sequencer is idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   // count agrees with the returned indices
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_match_count != '0) |->
         (sirs_pkg::CNT_W'(rsp_range_start + rsp_match_count) ==
          sirs_pkg::CNT_W'($unsigned(rsp_range_end) + sirs_pkg::CNT_W'(1))))
      else $error("match count inconsistent with range");
`endif

endmodule

`default_nettype wire

// ===== sv/sirs_bisect.sv =====
// Bisection datapath: the lo/hi window of one binary search and its midpoint.
// Depends on sirs_pkg for widths and the control struct.
`default_nettype none

module sirs_bisect (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sirs_pkg::bisect_ctrl_type     ctrl,
   input  wire logic [sirs_pkg::CNT_W-1:0]    n,
   output logic      [sirs_pkg::IDX_W-1:0]    mid,
   output logic      [sirs_pkg::CNT_W-1:0]    lo,
   output logic                               active
);

   logic [sirs_pkg::CNT_W-1:0] lo_ff, lo_in;
   logic [sirs_pkg::CNT_W-1:0] hi_ff, hi_in;
   logic [sirs_pkg::CNT_W:0]   sum;

   // midpoint of the open window; always below hi, so it fits an index
   assign sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid    = sum[sirs_pkg::IDX_W:1];
   assign lo     = lo_ff;
   assign active = lo_ff < hi_ff;

   // window update
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (ctrl.init) begin
         lo_in = '0;
         hi_in = n;
      end else if (ctrl.step) begin
         if (ctrl.go_right) begin
            lo_in = {1'b0, mid} + sirs_pkg::CNT_W'(1);
         end else begin
            hi_in = {1'b0, mid};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

`ifndef NO_ASSERTIONS
   // a halving is only applied to a non-empty window
   a_step_open: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> lo_ff < hi_ff)
      else $error("bisect step on empty window");

   // the window never inverts
   a_window_order: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("bisect window inverted");

   // a step always shrinks the window
   a_shrink: assert property (@(posedge clock) disable iff (reset)
      ctrl.step && !ctrl.init |=> (hi_ff - lo_ff) < $past(hi_ff - lo_ff))
      else $error("bisect window did not shrink");
`endif

endmodule

`default_nettype wire
